>>> src/hhc_pkg.sv
// hhc_pkg: shared types, codes and constants of the heating hysteresis controller
// no dependencies; imported by every module of the block

package hhc_pkg;

    localparam int TEMP_W    = 12;
    localparam int CMP_W     = 14;
    localparam int MINUTES_W = 11;
    localparam int RUNTIME_W = 17;
    localparam int STAMP_W   = 32;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;
    localparam int FUNC_W     = 2;

    localparam logic signed [CMP_W-1:0] SOIL_MARGIN     = 14'sd2;
    localparam logic signed [CMP_W-1:0] AIR_MARGIN      = 14'sd10;
    localparam logic signed [CMP_W-1:0] WATER_MARGIN    = 14'sd10;
    localparam logic signed [CMP_W-1:0] MIN_WATER_DELTA = 14'sd50;
    localparam logic [RUNTIME_W-1:0]    SECONDS_PER_MIN = 17'd60;
    localparam logic [RUNTIME_W-1:0]    RUNTIME_MAX     = 17'h1FFFF;

    // function codes carried on tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE   = 2'd0,
        FUNC_TO_DAY   = 2'd1,
        FUNC_TO_NIGHT = 2'd2
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAY_WATER   = 3'd0,
        CFG_NIGHT_WATER = 3'd1,
        CFG_DAY_SOIL    = 3'd2,
        CFG_NIGHT_SOIL  = 3'd3,
        CFG_DAY_AIR     = 3'd4,
        CFG_NIGHT_AIR   = 3'd5,
        CFG_DAY_LIMIT   = 3'd6,
        CFG_NIGHT_LIMIT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] day_water_target;
        logic signed [TEMP_W-1:0] night_water_target;
        logic signed [TEMP_W-1:0] day_soil_target;
        logic signed [TEMP_W-1:0] night_soil_target;
        logic signed [TEMP_W-1:0] day_air_target;
        logic signed [TEMP_W-1:0] night_air_target;
        logic [MINUTES_W-1:0]     day_limit_minutes;
        logic [MINUTES_W-1:0]     night_limit_minutes;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     hour_known;
        logic                     is_day;
        logic signed [TEMP_W-1:0] water_temp;
        logic signed [TEMP_W-1:0] soil_temp;
        logic                     soil_known;
        logic signed [TEMP_W-1:0] air_temp;
        logic                     air_known;
        logic [STAMP_W-1:0]       uptime_seconds;
    } in_item_t;

    typedef struct packed {
        logic                 heater;
        logic                 soil;
        logic                 air;
        logic                 stamp_valid;
        logic [STAMP_W-1:0]   last_stamp;
        logic [RUNTIME_W-1:0] day_seconds;
        logic [RUNTIME_W-1:0] night_seconds;
    } ctrl_state_t;

endpackage

>>> src/hhc_cfg_regs.sv
// hhc_cfg_regs: configuration register file, written through a plain write port
// depends on hhc_pkg

module hhc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hhc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [hhc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output hhc_pkg::cfg_t                    cfg
);
    import hhc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DAY_WATER:   cfg_reg.day_water_target   <= cfg_wr_data;
                CFG_NIGHT_WATER: cfg_reg.night_water_target <= cfg_wr_data;
                CFG_DAY_SOIL:    cfg_reg.day_soil_target    <= cfg_wr_data;
                CFG_NIGHT_SOIL:  cfg_reg.night_soil_target  <= cfg_wr_data;
                CFG_DAY_AIR:     cfg_reg.day_air_target     <= cfg_wr_data;
                CFG_NIGHT_AIR:   cfg_reg.night_air_target   <= cfg_wr_data;
                CFG_DAY_LIMIT:   cfg_reg.day_limit_minutes  <= cfg_wr_data[MINUTES_W-1:0];
                CFG_NIGHT_LIMIT: cfg_reg.night_limit_minutes <= cfg_wr_data[MINUTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/hhc_step.sv
// hhc_step: combinational next-state logic for one item (thermostats, runtime, limit)
// depends on hhc_pkg

module hhc_step (
    input  hhc_pkg::cfg_t        cfg,
    input  hhc_pkg::ctrl_state_t state,
    input  hhc_pkg::in_item_t    item,
    output hhc_pkg::ctrl_state_t state_next,
    output logic                 blocked
);
    import hhc_pkg::*;

    logic [RUNTIME_W-1:0]     total;
    logic [RUNTIME_W-1:0]     limit;
    logic [STAMP_W-1:0]       elapsed;
    logic [RUNTIME_W:0]       sum_wide;
    logic [RUNTIME_W-1:0]     sum;
    logic signed [CMP_W-1:0]  water, soil, air, wt, st, at;
    logic                     soil_delta, air_delta, soil_req, air_req, heat;

    always_comb begin
        state_next = state;
        blocked    = 1'b0;
        total      = item.is_day ? state.day_seconds : state.night_seconds;
        limit      = RUNTIME_W'(item.is_day ? cfg.day_limit_minutes
                                            : cfg.night_limit_minutes) * SECONDS_PER_MIN;
        elapsed    = item.uptime_seconds - state.last_stamp;
        sum_wide   = {1'b0, total} + {1'b0, elapsed[RUNTIME_W-1:0]};
        sum        = (|elapsed[STAMP_W-1:RUNTIME_W] || sum_wide[RUNTIME_W]) ? RUNTIME_MAX
                                                                           : sum_wide[RUNTIME_W-1:0];
        water      = CMP_W'(item.water_temp);
        soil       = CMP_W'(item.soil_temp);
        air        = CMP_W'(item.air_temp);
        wt         = CMP_W'(item.is_day ? cfg.day_water_target : cfg.night_water_target);
        st         = CMP_W'(item.is_day ? cfg.day_soil_target : cfg.night_soil_target);
        at         = CMP_W'(item.is_day ? cfg.day_air_target : cfg.night_air_target);
        soil_delta = water >= soil + MIN_WATER_DELTA;
        air_delta  = water >= air + MIN_WATER_DELTA;
        soil_req   = state.soil;
        air_req    = state.air;
        heat       = state.heater;

        unique case (item.func)
            FUNC_UPDATE: begin
                if (item.hour_known) begin
                    // heater on-time since the last stamp, saturating
                    if (state.heater && state.stamp_valid) begin
                        if (sum >= limit) begin
                            heat = 1'b0;
                        end
                        total = sum;
                    end
                    if (item.is_day) begin
                        state_next.day_seconds = total;
                    end else begin
                        state_next.night_seconds = total;
                    end
                    state_next.last_stamp  = item.uptime_seconds;
                    state_next.stamp_valid = 1'b1;

                    if (item.soil_known) begin
                        if (soil < st - SOIL_MARGIN) begin
                            soil_req        = 1'b1;
                            state_next.soil = soil_delta;
                        end else if (soil > st + SOIL_MARGIN) begin
                            soil_req        = 1'b0;
                            state_next.soil = 1'b0;
                        end
                    end
                    if (item.air_known) begin
                        if (air < at - AIR_MARGIN) begin
                            air_req        = 1'b1;
                            state_next.air = air_delta;
                        end else if (air > at + AIR_MARGIN) begin
                            air_req        = 1'b0;
                            state_next.air = 1'b0;
                        end
                    end
                    // raw readings still gate the drives
                    if (!soil_delta) begin
                        state_next.soil = 1'b0;
                    end
                    if (!air_delta) begin
                        state_next.air = 1'b0;
                    end

                    if (water < wt - WATER_MARGIN) begin
                        if (soil_req || air_req) begin
                            if (total != '0 && total >= limit) begin
                                blocked = 1'b1;
                            end else begin
                                heat = 1'b1;
                            end
                        end else begin
                            heat = 1'b0;
                        end
                    end else if (water > wt + WATER_MARGIN) begin
                        heat = 1'b0;
                    end
                    state_next.heater = heat;
                end
            end
            FUNC_TO_DAY: begin
                state_next.day_seconds = '0;
                state_next.stamp_valid = 1'b0;
            end
            FUNC_TO_NIGHT: begin
                state_next.night_seconds = '0;
                state_next.stamp_valid   = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

>>> src/heating_hysteresis_controller_core.sv
// heating_hysteresis_controller_core: top level with input stage, state and result register
// depends on hhc_pkg, hhc_cfg_regs and hhc_step
//
// Usage: items enter on the s_ stream (tdata = sensor readings and uptime, tuser = function
// code) and each accepted item yields exactly one result on the m_ stream (heater drives,
// blocked flag and the day and night runtime totals). An accepted item is held in the input
// register; the step logic then updates the controller state and loads the result register,
// which drives m_tvalid. One item per cycle is sustained while m_tready is high: the next
// item is taken while the previous one is being evaluated, and the combinational step
// logic closes the state loop between consecutive items.
// When m_tready is low with a result held, the input register keeps its item and s_tready
// falls only once both stages are full; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears both stages, all drives, the runtime totals, the
// timestamp and every configuration register. Configuration writes through cfg_wr_en,
// cfg_addr and cfg_wr_data take effect at the next clock edge and belong to idle periods.

module heating_hysteresis_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hhc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [hhc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hour_known, is_day, water_temp[11:0], soil_temp[11:0], soil_known,
    // air_temp[11:0], air_known, uptime_seconds[31:0]
    input  logic [hhc_pkg::IN_DATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [hhc_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // water_heater_on, soil_heat_on, air_heat_on, heater_blocked,
    // day_runtime[16:0], night_runtime[16:0], two zero pad bits
    output logic [hhc_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import hhc_pkg::*;

    cfg_t        cfg;
    in_item_t    in_item;
    in_item_t    item_reg;
    logic        item_valid_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        blocked;
    logic        blocked_reg;
    logic        out_valid_reg;
    logic        advance;

    hhc_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    always_comb begin
        in_item.func           = s_tuser;
        in_item.hour_known     = s_tdata[0];
        in_item.is_day         = s_tdata[1];
        in_item.water_temp     = s_tdata[13:2];
        in_item.soil_temp      = s_tdata[25:14];
        in_item.soil_known     = s_tdata[26];
        in_item.air_temp       = s_tdata[38:27];
        in_item.air_known      = s_tdata[39];
        in_item.uptime_seconds = s_tdata[71:40];
    end

    hhc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .blocked    (blocked)
    );

    // item moves into the result register when that register is free or draining
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            blocked_reg   <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                blocked_reg   <= blocked;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, state_reg.night_seconds, state_reg.day_seconds, blocked_reg,
                       state_reg.air, state_reg.soil, state_reg.heater};

endmodule
